// ===== design/hsort_pkg.sv =====
// shared types, constants and helpers for the heap sorter
`default_nettype none

package hsort_pkg;

    localparam int unsigned MaxItemsDef = 64;
    localparam int unsigned ValW        = 32;
    localparam int unsigned TallyW      = 16;
    localparam logic [TallyW-1:0] TallyMax = {TallyW{1'b1}};

    typedef enum logic [3:0] {
        S_LOAD,
        S_BUILD,
        S_EXTRACT,
        S_EX_RD,
        S_EX_W0,
        S_EX_W1,
        S_SD_NODE,
        S_SD_LEFT,
        S_SD_RIGHT,
        S_SD_CMP,
        S_SD_SWAP,
        S_OUT
    } t_state;

    typedef enum logic {
        PH_BUILD,
        PH_EXTRACT
    } t_phase;

    // saturating tally increment
    function automatic logic [TallyW-1:0] tally_bump(input logic [TallyW-1:0] t);
        return (t == TallyMax) ? t : t + {{(TallyW-1){1'b0}}, 1'b1};
    endfunction

endpackage

`default_nettype wire

// ===== design/hsort_mem.sv =====
// value store: one write port, one read port with registered read data
`default_nettype none

module hsort_mem
    import hsort_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = MaxItemsDef,
    parameter int unsigned AW        = $clog2(MAX_ITEMS)
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire logic [ValW-1:0] i_wdata,
    input  wire logic [AW-1:0]   i_raddr,
    output logic      [ValW-1:0] o_rdata
);

    logic [ValW-1:0] r_mem [MAX_ITEMS];
    logic [ValW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/hsort_ctrl.sv =====
// load, heap build, extraction and readout sequencer with the operation tallies
`default_nettype none

module hsort_ctrl
    import hsort_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = MaxItemsDef,
    parameter int unsigned AW        = $clog2(MAX_ITEMS),
    parameter int unsigned CW        = $clog2(MAX_ITEMS + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [ValW-1:0]   i_value,
    input  wire logic              i_last_in,
    output logic                   o_busy,
    // memory side
    output logic                   o_we,
    output logic      [AW-1:0]     o_waddr,
    output logic      [ValW-1:0]   o_wdata,
    output logic      [AW-1:0]     o_raddr,
    input  wire logic [ValW-1:0]   i_rdata,
    // result side
    output logic                   o_emit,
    output logic                   o_emit_last,
    output logic      [TallyW-1:0] o_compare_count,
    output logic      [TallyW-1:0] o_copy_count,
    output logic                   o_overflowed
);

    localparam int unsigned IW = AW + 2;
    localparam logic [CW-1:0] CapCount = CW'(MAX_ITEMS);

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_size, n_size;
    logic [CW-1:0]     r_i, n_i;
    logic [AW-1:0]     r_node, n_node;
    logic [AW-1:0]     r_largest, n_largest;
    logic [AW-1:0]     r_k, n_k;
    logic [ValW-1:0]   r_node_val, n_node_val;
    logic [ValW-1:0]   r_left_val, n_left_val;
    logic [TallyW-1:0] r_cmp, n_cmp;
    logic [TallyW-1:0] r_copy, n_copy;
    logic              r_ovf, n_ovf;
    logic              r_emit, n_emit;
    logic              r_emit_last, n_emit_last;
    logic [TallyW-1:0] r_o_cmp, n_o_cmp;
    logic [TallyW-1:0] r_o_copy, n_o_copy;
    logic              r_o_ovf, n_o_ovf;

    logic [IW-1:0]     w_left, w_right, w_size;
    logic [CW-1:0]     w_count_after;
    logic [CW-1:0]     w_i_dec;
    logic              w_left_in, w_right_in;
    logic              w_take_left, w_take_right;
    logic [ValW-1:0]   w_after_left;

    assign w_left  = {1'b0, r_node, 1'b1};
    assign w_right = w_left + IW'(1);
    assign w_size  = IW'(r_size);
    assign w_left_in  = (w_left < w_size);
    assign w_right_in = (w_right < w_size);
    assign w_i_dec = r_i - CW'(1);
    assign w_count_after = (r_count < CapCount) ? r_count + CW'(1) : r_count;

    // child beats current largest only if strictly greater; ties keep the parent, and the left child over the right
    assign w_take_left  = w_left_in && ($signed(r_left_val) > $signed(r_node_val));
    assign w_after_left = w_take_left ? r_left_val : r_node_val;
    assign w_take_right = w_right_in && ($signed(i_rdata) > $signed(w_after_left));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_phase <= PH_BUILD;
            r_count <= '0;
            r_cmp   <= '0;
            r_copy  <= '0;
            r_ovf   <= 1'b0;
            r_emit  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_count <= n_count;
            r_cmp   <= n_cmp;
            r_copy  <= n_copy;
            r_ovf   <= n_ovf;
            r_emit  <= n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size      <= n_size;
        r_i         <= n_i;
        r_node      <= n_node;
        r_largest   <= n_largest;
        r_k         <= n_k;
        r_node_val  <= n_node_val;
        r_left_val  <= n_left_val;
        r_emit_last <= n_emit_last;
        r_o_cmp     <= n_o_cmp;
        r_o_copy    <= n_o_copy;
        r_o_ovf     <= n_o_ovf;
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_count     = r_count;
        n_size      = r_size;
        n_i         = r_i;
        n_node      = r_node;
        n_largest   = r_largest;
        n_k         = r_k;
        n_node_val  = r_node_val;
        n_left_val  = r_left_val;
        n_cmp       = r_cmp;
        n_copy      = r_copy;
        n_ovf       = r_ovf;
        n_emit      = 1'b0;
        n_emit_last = 1'b0;
        n_o_cmp     = r_o_cmp;
        n_o_copy    = r_o_copy;
        n_o_ovf     = r_o_ovf;
        o_we        = 1'b0;
        o_waddr     = r_node;
        o_wdata     = r_node_val;
        o_raddr     = r_node;

        case (r_state)
            S_LOAD: begin
                if (i_start) begin
                    if (r_count < CapCount) begin
                        o_we    = 1'b1;
                        o_waddr = r_count[AW-1:0];
                        o_wdata = i_value;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_count = w_count_after;
                    if (i_last_in) begin
                        n_cmp   = '0;
                        n_copy  = '0;
                        n_size  = w_count_after;
                        n_i     = w_count_after >> 1;
                        n_phase = PH_BUILD;
                        n_state = S_BUILD;
                    end
                end
            end
            S_BUILD: begin
                if (r_i == '0) begin
                    n_i     = r_count;
                    n_size  = r_count;
                    n_phase = PH_EXTRACT;
                    n_state = S_EXTRACT;
                end else begin
                    n_i     = w_i_dec;
                    n_node  = w_i_dec[AW-1:0];
                    n_state = S_SD_NODE;
                end
            end
            S_EXTRACT: begin
                if (r_i <= CW'(1)) begin
                    n_k     = '0;
                    n_state = S_OUT;
                end else begin
                    o_raddr = '0;
                    n_state = S_EX_RD;
                end
            end
            S_EX_RD: begin
                n_node_val = i_rdata;
                o_raddr    = w_i_dec[AW-1:0];
                n_state    = S_EX_W0;
            end
            S_EX_W0: begin
                o_we    = 1'b1;
                o_waddr = '0;
                o_wdata = i_rdata;
                n_state = S_EX_W1;
            end
            S_EX_W1: begin
                o_we    = 1'b1;
                o_waddr = w_i_dec[AW-1:0];
                o_wdata = r_node_val;
                n_copy  = tally_bump(r_copy);
                n_size  = w_i_dec;
                n_i     = w_i_dec;
                n_node  = '0;
                n_state = S_SD_NODE;
            end
            S_SD_NODE: begin
                if (w_left_in) begin
                    o_raddr = r_node;
                    n_state = S_SD_LEFT;
                end else begin
                    n_state = (r_phase == PH_BUILD) ? S_BUILD : S_EXTRACT;
                end
            end
            S_SD_LEFT: begin
                n_node_val = i_rdata;
                o_raddr    = w_left[AW-1:0];
                n_state    = S_SD_RIGHT;
            end
            S_SD_RIGHT: begin
                n_left_val = i_rdata;
                o_raddr    = w_right[AW-1:0];
                n_state    = S_SD_CMP;
            end
            S_SD_CMP: begin
                // both child hits count, at most two per level
                if (w_take_left && w_take_right) begin
                    n_cmp = tally_bump(tally_bump(r_cmp));
                end else if (w_take_left || w_take_right) begin
                    n_cmp = tally_bump(r_cmp);
                end
                if (w_take_left || w_take_right) begin
                    o_we      = 1'b1;
                    o_waddr   = r_node;
                    o_wdata   = w_take_right ? i_rdata : r_left_val;
                    n_largest = w_take_right ? w_right[AW-1:0] : w_left[AW-1:0];
                    n_state   = S_SD_SWAP;
                end else begin
                    n_state = (r_phase == PH_BUILD) ? S_BUILD : S_EXTRACT;
                end
            end
            S_SD_SWAP: begin
                o_we    = 1'b1;
                o_waddr = r_largest;
                o_wdata = r_node_val;
                n_copy  = tally_bump(r_copy);
                n_node  = r_largest;
                n_state = S_SD_NODE;
            end
            S_OUT: begin
                o_raddr  = r_k;
                n_emit   = 1'b1;
                n_o_cmp  = r_cmp;
                n_o_copy = r_copy;
                n_o_ovf  = r_ovf;
                if (CW'(r_k) + CW'(1) == r_count) begin
                    n_emit_last = 1'b1;
                    n_count     = '0;
                    n_ovf       = 1'b0;
                    n_state     = S_LOAD;
                end else begin
                    n_k = r_k + AW'(1);
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_busy          = (r_state != S_LOAD);
    assign o_emit          = r_emit;
    assign o_emit_last     = r_emit_last;
    assign o_compare_count = r_o_cmp;
    assign o_copy_count    = r_o_copy;
    assign o_overflowed    = r_o_ovf;

endmodule

`default_nettype wire

// ===== design/heap_sort_with_counters.sv =====
// heap sorter top level: sequencer and value store
//
//  channel   handshake            payload
//  -------   ------------------   ------------------------------------------------
//  input     start / busy         i_value, i_last_in
//  result    o_strobe (1 cycle)   o_sorted_value, o_last_out, o_compare_count,
//                                 o_copy_count, o_overflowed
//
// loading takes one word per cycle in which start is high; the word marked last starts the sort
// sorting builds the heap, then swaps the root with the last heap word and sifts down;
// each sift level reads the node and both children, compares, and swaps if a child wins
// results follow one per cycle, the first in the cycle after readout begins
// busy goes high once the last word is taken and drops in the cycle the final result shows
// synchronous active-low reset returns to loading; the receiver cannot stall
`default_nettype none

module heap_sort_with_counters
    import hsort_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = MaxItemsDef
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [ValW-1:0]   i_value,
    input  wire logic                     i_last_in,
    output logic                          o_strobe,
    output logic signed      [ValW-1:0]   o_sorted_value,
    output logic                          o_last_out,
    output logic             [TallyW-1:0] o_compare_count,
    output logic             [TallyW-1:0] o_copy_count,
    output logic                          o_overflowed
);

    localparam int unsigned AW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [ValW-1:0] w_wdata;
    logic [AW-1:0]   w_raddr;
    logic [ValW-1:0] w_rdata;

    hsort_ctrl #(
        .MAX_ITEMS (MAX_ITEMS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_value         (i_value),
        .i_last_in       (i_last_in),
        .o_busy          (busy),
        .o_we            (w_we),
        .o_waddr         (w_waddr),
        .o_wdata         (w_wdata),
        .o_raddr         (w_raddr),
        .i_rdata         (w_rdata),
        .o_emit          (o_strobe),
        .o_emit_last     (o_last_out),
        .o_compare_count (o_compare_count),
        .o_copy_count    (o_copy_count),
        .o_overflowed    (o_overflowed)
    );

    hsort_mem #(
        .MAX_ITEMS (MAX_ITEMS),
        .AW        (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // result word comes straight from the store read register
    assign o_sorted_value = $signed(w_rdata);

    // only the final word of a run may show while loading is open again
    a_idle_strobe_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !busy) |-> o_last_out)
        else $error("result word shown while idle without last mark");

    // readout is gapless until the last word
    a_readout_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_out) |=> o_strobe)
        else $error("gap in result readout");

    // last word ends the run
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_out) |=> !o_strobe)
        else $error("result after last word");

    a_last_needs_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_out |-> o_strobe)
        else $error("last mark without strobe");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// self-checking testbench for the heap sorter with operation counters
`timescale 1ns / 100ps

module tb;
    import hsort_pkg::*;

    localparam int unsigned Cap       = MaxItemsDef;
    localparam int unsigned CycleCap  = 500000;
    localparam int unsigned DrainWait = 40;

    typedef struct {
        logic signed [ValW-1:0]   value;
        logic                     last;
        logic        [TallyW-1:0] compares;
        logic        [TallyW-1:0] copies;
        logic                     dropped;
    } t_sorted_word;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic signed [ValW-1:0]     i_value = '0;
    logic                       i_last_in = 1'b0;
    logic                       o_strobe;
    logic signed [ValW-1:0]     o_sorted_value;
    logic                       o_last_out;
    logic        [TallyW-1:0]   o_compare_count;
    logic        [TallyW-1:0]   o_copy_count;
    logic                       o_overflowed;

    // predictor state
    logic signed [ValW-1:0]     heap_store [Cap];
    int unsigned                loaded_count = 0;
    logic        [TallyW-1:0]   compare_tally = '0;
    logic        [TallyW-1:0]   copy_tally = '0;
    logic                       drop_mark = 1'b0;

    t_sorted_word               sorted_words_due [$];
    logic signed [ValW-1:0]     set_buf [$];
    int unsigned                sender_idle_pct = 0;
    int unsigned                error_count = 0;
    int unsigned                words_checked = 0;
    int unsigned                words_sent = 0;
    int unsigned                sets_sorted = 0;
    int unsigned                sets_dropping = 0;
    int unsigned                cycle_count = 0;

    heap_sort_with_counters dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_value         (i_value),
        .i_last_in       (i_last_in),
        .o_strobe        (o_strobe),
        .o_sorted_value  (o_sorted_value),
        .o_last_out      (o_last_out),
        .o_compare_count (o_compare_count),
        .o_copy_count    (o_copy_count),
        .o_overflowed    (o_overflowed)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleCap) begin
            $display("%0t: timeout with %0d words still due", $time, sorted_words_due.size());
            $display("tb failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    task automatic sift_heap(input int unsigned size, input int unsigned node);
        int unsigned            top;
        int unsigned            lt;
        int unsigned            rt;
        logic signed [ValW-1:0] tmp;
        bit                     settled;
        settled = 1'b0;
        while (!settled) begin
            top = node;
            lt  = 2 * node + 1;
            rt  = 2 * node + 2;
            // ties never count as a win
            if (lt < size && heap_store[lt] > heap_store[top]) begin
                if (compare_tally != '1) compare_tally = compare_tally + 1'b1;
                top = lt;
            end
            if (rt < size && heap_store[rt] > heap_store[top]) begin
                if (compare_tally != '1) compare_tally = compare_tally + 1'b1;
                top = rt;
            end
            if (top == node) begin
                settled = 1'b1;
            end else begin
                tmp              = heap_store[node];
                heap_store[node] = heap_store[top];
                heap_store[top]  = tmp;
                if (copy_tally != '1) copy_tally = copy_tally + 1'b1;
                node = top;
            end
        end
    endtask

    task automatic stage_word(input logic signed [ValW-1:0] v, input logic last);
        int unsigned            n;
        int unsigned            i;
        logic signed [ValW-1:0] tmp;
        t_sorted_word           w;
        if (loaded_count < Cap) begin
            heap_store[loaded_count] = v;
            loaded_count++;
        end else begin
            drop_mark = 1'b1;
        end
        if (last) begin
            compare_tally = '0;
            copy_tally    = '0;
            n = loaded_count;
            for (i = n / 2; i > 0; i--) sift_heap(n, i - 1);
            for (i = n; i > 1; i--) begin
                tmp               = heap_store[0];
                heap_store[0]     = heap_store[i - 1];
                heap_store[i - 1] = tmp;
                if (copy_tally != '1) copy_tally = copy_tally + 1'b1;
                sift_heap(i - 1, 0);
            end
            for (i = 0; i < n; i++) begin
                w.value    = heap_store[i];
                w.last     = (i + 1 == n);
                w.compares = compare_tally;
                w.copies   = copy_tally;
                w.dropped  = drop_mark;
                sorted_words_due.push_back(w);
            end
            if (drop_mark) sets_dropping++;
            sets_sorted++;
            loaded_count  = 0;
            compare_tally = '0;
            copy_tally    = '0;
            drop_mark     = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------- checker

    task automatic check_field(input string name, input logic signed [32:0] want,
                               input logic signed [32:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_sorted_word w;
        if (i_rst_n && o_strobe) begin
            if (sorted_words_due.size() == 0) begin
                $display("%0t: unexpected word, expected none got %0d", $time,
                         o_sorted_value);
                error_count++;
            end else begin
                w = sorted_words_due.pop_front();
                check_field("sorted_value", 33'(w.value), 33'(o_sorted_value));
                check_field("last_out", 33'(w.last), 33'(o_last_out));
                check_field("compare_count", 33'(w.compares), 33'(o_compare_count));
                check_field("copy_count", 33'(w.copies), 33'(o_copy_count));
                check_field("overflowed", 33'(w.dropped), 33'(o_overflowed));
                words_checked++;
            end
        end
    end

    // ---------------------------------------------------------------- driver

    // start is only lowered in idle cycles, so back-to-back words keep it high
    task automatic send_word(input logic signed [ValW-1:0] v, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            start     <= 1'b0;
            i_value   <= $urandom;
            i_last_in <= 1'($urandom_range(1));
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_value   <= v;
        i_last_in <= last;
        do @(posedge i_clk); while (busy);
        stage_word(v, last);
        words_sent++;
    endtask

    task automatic send_set();
        foreach (set_buf[k]) send_word(set_buf[k], k == set_buf.size() - 1);
        set_buf.delete();
    endtask

    function automatic logic signed [ValW-1:0] pick_value();
        logic signed [ValW-1:0] v;
        case ($urandom_range(5))
            0: v = $signed($urandom_range(6)) - 3;  // dense ties
            1: begin
                case ($urandom_range(3))
                    0: v = 32'sh7fffffff;
                    1: v = 32'sh80000000;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_single_words();
        send_word(32'sh80000000, 1'b1);
        send_word(32'sh7fffffff, 1'b1);
    endtask

    task automatic test_extremes_and_ties();
        set_buf = {32'sh7fffffff, 32'sh80000000, 0, -1, 1, 32'sh80000000,
                   32'sh7fffffff, 32'sh55555555, 32'shaaaaaaaa};
        send_set();
        // equal values never win a comparison
        set_buf = {7, 7, 7, 7};
        send_set();
        // already a max-heap, then already ascending
        set_buf = {5, 4, 3, 2, 1};
        send_set();
        set_buf = {-2, -1, 0, 1, 2};
        send_set();
    endtask

    task automatic test_capacity();
        // exactly full, then full plus dropped words including the last one
        repeat (Cap) set_buf.push_back(pick_value());
        send_set();
        repeat (Cap + 2) set_buf.push_back(pick_value());
        send_set();
    endtask

    task automatic test_random_sets(input int unsigned n_words, input int unsigned idle_pct);
        int unsigned sent;
        int unsigned size;
        sender_idle_pct = idle_pct;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(11) == 0) size = $urandom_range(40, 11);
            else size = $urandom_range(10, 1);
            repeat (size) set_buf.push_back(pick_value());
            send_set();
            sent += size;
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 37;
        test_single_words();
        test_extremes_and_ties();
        test_capacity();
        test_random_sets(32, 37);
        test_random_sets(32, 61);
        test_random_sets(32, 0);

        start <= 1'b0;
        while (sorted_words_due.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);

        $display("sent %0d words in %0d sets (%0d with dropped words)", words_sent,
                 sets_sorted, sets_dropping);
        $display("checked %0d sorted words, %0d errors", words_checked, error_count);
        if (error_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/hsort_pkg.sv
design/hsort_mem.sv
design/hsort_ctrl.sv
design/heap_sort_with_counters.sv
sim/tb.sv
